### hdl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared command codes, result status codes and the compare result type of
// the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  // Key width, fixed by the command format.
  localparam int unsigned KeyWidth = 32;

  // Command codes.
  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdDelete = 2'd1;
  localparam logic [1:0] CmdList   = 2'd2;

  // Result status codes.
  localparam logic [2:0] StInserted = 3'd0;
  localparam logic [2:0] StDeleted  = 3'd1;
  localparam logic [2:0] StNotFound = 3'd2;
  localparam logic [2:0] StEmpty    = 3'd3;
  localparam logic [2:0] StFull     = 3'd4;
  localparam logic [2:0] StList     = 3'd5;

  // Outcome of one signed comparison of a stored key against the command key.
  typedef struct packed {
    logic gt;  // stored key is greater than the command key
    logic eq;  // stored key equals the command key
  } cmp_res_t;

endpackage

### hdl/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram
// Generic single write port, single read port RAM with a registered read.
// The read data holds its value while no read is requested.
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Storage and registered read; contents are not reset.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/skt_cmp.sv
// ----------------------------------------------------------------------------
// skt_cmp
// Shared signed key comparator used by the insert and delete scans of the table.
// ----------------------------------------------------------------------------
module skt_cmp
  import skt_pkg::*;
(
  input  logic signed [KeyWidth-1:0] stored_i,
  input  logic signed [KeyWidth-1:0] key_i,
  output cmp_res_t                   res_o
);

  // One magnitude compare and one equality compare on the two keys.
  always_comb begin
    res_o.gt = (stored_i > key_i);
    res_o.eq = (stored_i == key_i);
  end

endmodule

### hdl/sorted_key_table_core.sv
// ----------------------------------------------------------------------------
// sorted_key_table_core
// Bounded table of signed keys held in ascending order in a RAM.
// ----------------------------------------------------------------------------
// The table holds up to CAPACITY signed 32-bit keys in ascending order in a
// single RAM, walked by a small sequencer around one shared comparator. An
// insert walks down from the top and moves each key above the new key's slot
// up one at a time. A delete makes one full pass that finds the key and closes
// the gap behind it, and a list streams the keys out in order, reading one slot
// before it issues each key. A rejected insert and a delete or list on an empty
// table go straight to issuing their status result, and an unused command code
// is consumed without holding the input off. The cost of each pass is set by
// the single RAM read port, whose data is registered, so each visited slot
// takes a read state and a compare or output state. Results wait in an output
// register, so a stall on the result side only holds the sequencer in the state
// that issues a result. The block accepts no new command until the current one
// has issued its last result.
// ----------------------------------------------------------------------------
module sorted_key_table_core
  import skt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Command channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 cmd_i,
  input  logic signed [KeyWidth-1:0] key_i,
  // Result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 status_o,
  output logic signed [KeyWidth-1:0] key_out_o,
  output logic                       last_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Sequencer state codes.
  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SInsRd  = 3'd1;
  localparam logic [2:0] SInsCmp = 3'd2;
  localparam logic [2:0] SDelRd  = 3'd3;
  localparam logic [2:0] SDelCmp = 3'd4;
  localparam logic [2:0] SLstRd  = 3'd5;
  localparam logic [2:0] SLstOut = 3'd6;
  localparam logic [2:0] SResp   = 3'd7;

  logic [2:0]                 state_q, state_d;
  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              idx_q, idx_d;
  logic                       found_q, found_d;
  logic [2:0]                 resp_q, resp_d;
  logic signed [KeyWidth-1:0] key_q, key_d;

  logic                       out_valid_q, out_valid_d;
  logic [2:0]                 status_q, status_d;
  logic signed [KeyWidth-1:0] key_out_q, key_out_d;
  logic                       last_q, last_d;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [KeyWidth-1:0]        mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [KeyWidth-1:0]        mem_rdata;
  cmp_res_t                   cmp_res;

  logic                       in_xfer;
  logic                       out_free;

  // Key store.
  skt_ram #(
    .Width (KeyWidth),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Shared comparator between the slot just read and the command key.
  skt_cmp u_cmp (
    .stored_i (mem_rdata),
    .key_i    (key_q),
    .res_o    (cmp_res)
  );

  assign in_stall_o = (state_q != SIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  // The output register can take a new result when empty or being drained.
  assign out_free   = !out_valid_q || !out_stall_i;

  // Sequencer, RAM control and result register loading.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    found_d     = found_q;
    resp_d      = resp_q;
    key_d       = key_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    key_out_d   = key_out_q;
    last_d      = last_q;
    mem_we      = 1'b0;
    mem_waddr   = AW'(idx_q);
    mem_wdata   = key_q;
    mem_re      = 1'b0;
    mem_raddr   = AW'(idx_q);

    unique case (state_q)
      SIdle: begin
        if (in_xfer) begin
          key_d   = key_i;
          found_d = 1'b0;
          case (cmd_i)
            CmdInsert: begin
              if (count_q == CW'(CAPACITY)) begin
                resp_d  = StFull;
                state_d = SResp;
              end else begin
                idx_d   = count_q;
                state_d = SInsRd;
              end
            end
            CmdDelete: begin
              if (count_q == '0) begin
                resp_d  = StEmpty;
                state_d = SResp;
              end else begin
                idx_d   = '0;
                state_d = SDelRd;
              end
            end
            CmdList: begin
              if (count_q == '0) begin
                resp_d  = StEmpty;
                state_d = SResp;
              end else begin
                idx_d   = '0;
                state_d = SLstRd;
              end
            end
            default: begin
              // The unused code is consumed without effect.
              state_d = SIdle;
            end
          endcase
        end
      end

      // Walk down from the top, reading the slot below the free one.
      SInsRd: begin
        if (idx_q == '0) begin
          mem_we  = 1'b1;
          count_d = count_q + CW'(1);
          resp_d  = StInserted;
          state_d = SResp;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_q - CW'(1));
          state_d   = SInsCmp;
        end
      end

      // A greater key moves up one slot; otherwise the new key goes above it.
      SInsCmp: begin
        mem_we = 1'b1;
        if (cmp_res.gt) begin
          mem_wdata = mem_rdata;
          idx_d     = idx_q - CW'(1);
          state_d   = SInsRd;
        end else begin
          count_d = count_q + CW'(1);
          resp_d  = StInserted;
          state_d = SResp;
        end
      end

      // Walk up through every stored key.
      SDelRd: begin
        if (idx_q == count_q) begin
          if (found_q) begin
            count_d = count_q - CW'(1);
            resp_d  = StDeleted;
          end else begin
            resp_d  = StNotFound;
          end
          state_d = SResp;
        end else begin
          mem_re  = 1'b1;
          state_d = SDelCmp;
        end
      end

      // Before the first match, look for it; after it, move each key down.
      SDelCmp: begin
        if (found_q) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(idx_q - CW'(1));
          mem_wdata = mem_rdata;
        end else if (cmp_res.eq) begin
          found_d = 1'b1;
        end
        idx_d   = idx_q + CW'(1);
        state_d = SDelRd;
      end

      SLstRd: begin
        mem_re  = 1'b1;
        state_d = SLstOut;
      end

      // Issue one listed key once the output register is free.
      SLstOut: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = StList;
          key_out_d   = mem_rdata;
          last_d      = ((idx_q + CW'(1)) == count_q);
          if ((idx_q + CW'(1)) == count_q) begin
            state_d = SIdle;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = SLstRd;
          end
        end
      end

      // Issue the single status result of a command.
      SResp: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = resp_q;
          key_out_d   = '0;
          last_d      = 1'b1;
          state_d     = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    found_q   <= found_d;
    resp_q    <= resp_d;
    key_q     <= key_d;
    status_q  <= status_d;
    key_out_q <= key_out_d;
    last_q    <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign key_out_o   = key_out_q;
  assign last_o      = last_q;

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted key table core.
// ----------------------------------------------------------------------------
// Commands are queued up front by an initial block and presented by a clocked
// driver that sends in bursts with random gaps. Each accepted command is run
// through a local model of the ordered table, and the results it must produce
// are queued. A clocked monitor takes every result transfer and checks it,
// field by field, against the oldest queued result. The receiver stalls on a
// pattern of its own, including one long hold-off, and the sender waits for
// the table to drain at marked points.
// ----------------------------------------------------------------------------
module tb
  import skt_pkg::*;
();

  localparam int unsigned Capacity  = 16;
  localparam int unsigned CycleCap  = 200000;
  localparam int unsigned DrainWait = 100;

  // The package names no code for the fourth command value, which is ignored.
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam logic signed [KeyWidth-1:0] KeyMin = 32'sh8000_0000;
  localparam logic signed [KeyWidth-1:0] KeyMax = 32'sh7FFF_FFFF;

  typedef struct {
    logic [1:0]                 cmd;
    logic signed [KeyWidth-1:0] key;
    bit                         wait_drain;  // hold back until all results are in
  } table_cmd_t;

  typedef struct {
    logic [2:0]                 status;
    logic signed [KeyWidth-1:0] key_out;
    logic                       last;
  } table_result_t;

  // Clock, reset and block inputs, all known from time zero.
  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic [1:0]                 cmd_i       = CmdInsert;
  logic signed [KeyWidth-1:0] key_i       = '0;
  logic                       out_stall_i = 1'b0;

  logic                       in_stall_o;
  logic                       out_valid_o;
  logic [2:0]                 status_o;
  logic signed [KeyWidth-1:0] key_out_o;
  logic                       last_o;

  // Commands waiting to be sent and results waiting to arrive.
  table_cmd_t    cmd_queue[$];
  table_result_t due_results[$];
  table_result_t oldest_due;

  // Local copy of the ordered table.
  logic signed [KeyWidth-1:0] model_keys[Capacity];
  int unsigned                model_count = 0;

  int unsigned n_errors   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_cycles   = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned rcv_cycle  = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;

  sorted_key_table_core #(
    .CAPACITY(Capacity)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .key_i      (key_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .key_out_o  (key_out_o),
    .last_o     (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Queue one result that the table must produce.
  task automatic expect_result(input logic [2:0] status, input logic signed [KeyWidth-1:0] k,
                               input logic last);
    table_result_t r;
    r.status  = status;
    r.key_out = k;
    r.last    = last;
    due_results.push_back(r);
  endtask

  // Apply one command to the local table and queue the results it causes.
  task automatic apply_command(input logic [1:0] c, input logic signed [KeyWidth-1:0] k);
    int unsigned pos;
    int unsigned i;
    case (c)
      CmdInsert: begin
        if (model_count >= Capacity) begin
          expect_result(StFull, '0, 1'b1);
        end else begin
          // Equal keys stay ahead of the new one.
          pos = 0;
          while (pos < model_count && model_keys[pos] <= k) pos++;
          for (i = model_count; i > pos; i--) model_keys[i] = model_keys[i-1];
          model_keys[pos] = k;
          model_count++;
          expect_result(StInserted, '0, 1'b1);
        end
      end
      CmdDelete: begin
        if (model_count == 0) begin
          expect_result(StEmpty, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < model_count && model_keys[pos] != k) pos++;
          if (pos == model_count) begin
            expect_result(StNotFound, '0, 1'b1);
          end else begin
            for (i = pos; i + 1 < model_count; i++) model_keys[i] = model_keys[i+1];
            model_count--;
            expect_result(StDeleted, '0, 1'b1);
          end
        end
      end
      CmdList: begin
        if (model_count == 0) begin
          expect_result(StEmpty, '0, 1'b1);
        end else begin
          for (i = 0; i < model_count; i++)
            expect_result(StList, model_keys[i], (i + 1 == model_count));
        end
      end
      default: begin
        // The unused code changes nothing and produces nothing.
      end
    endcase
  endtask

  task automatic queue_cmd(input logic [1:0] c, input logic signed [KeyWidth-1:0] k,
                           input bit wait_drain);
    table_cmd_t t;
    t.cmd        = c;
    t.key        = k;
    t.wait_drain = wait_drain;
    cmd_queue.push_back(t);
  endtask

  // Mostly keys from a narrow band so that deletes hit and duplicates occur.
  function automatic logic signed [KeyWidth-1:0] pick_key();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      v = $urandom_range(0, 6);
      return v - 3;
    end
    if (r == 5) return KeyMin;
    if (r == 6) return KeyMax;
    return $urandom;
  endfunction

  // Insert-heavy phases fill the table, delete-heavy phases drain it.
  function automatic logic [1:0] pick_cmd(input bit filling);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return CmdUnused;
    if (r < 25) return CmdList;
    if (filling) return (r < 85) ? CmdInsert : CmdDelete;
    return (r < 85) ? CmdDelete : CmdInsert;
  endfunction

  // Command driver: bursts of random length with random gaps between them.
  always @(posedge clk_i) begin
    if (rst_ni && !(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        apply_command(cmd_i, key_i);
        n_accepted++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (cmd_queue.size() > 0 &&
                   !(cmd_queue[0].wait_drain && due_results.size() != 0)) begin
        in_valid_i <= 1'b1;
        cmd_i      <= cmd_queue[0].cmd;
        key_i      <= cmd_queue[0].key;
        void'(cmd_queue.pop_front());
        if (burst_left == 0) burst_left = $urandom_range(1, 20);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: a stall pattern that steps through four modes, plus one
  // long hold-off while the sender keeps offering commands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      rcv_cycle++;
      if (!hold_done && n_accepted >= 60) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        case ((rcv_cycle / 50) % 4)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= (rcv_cycle % 4 == 3);
        endcase
      end
    end
  end

  // Result monitor: every transfer is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d key_out %0d last %0b",
               status_o, key_out_o, last_o);
        n_errors++;
      end else begin
        oldest_due = due_results.pop_front();
        if (status_o !== oldest_due.status) begin
          $error("status: expected %0d, actual %0d", oldest_due.status, status_o);
          n_errors++;
        end
        if (key_out_o !== oldest_due.key_out) begin
          $error("key_out: expected %0d, actual %0d", oldest_due.key_out, key_out_o);
          n_errors++;
        end
        if (last_o !== oldest_due.last) begin
          $error("last: expected %0b, actual %0b", oldest_due.last, last_o);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CycleCap) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    // Empty table cases, and the unused code on an empty table.
    queue_cmd(CmdList, '0, 1'b0);
    queue_cmd(CmdDelete, 32'sd5, 1'b0);
    queue_cmd(CmdUnused, KeyMax, 1'b0);
    // Extremes, and a duplicate that must go after its equal.
    queue_cmd(CmdInsert, KeyMax, 1'b0);
    queue_cmd(CmdInsert, KeyMin, 1'b0);
    queue_cmd(CmdInsert, '0, 1'b0);
    queue_cmd(CmdInsert, '0, 1'b0);
    // Delete with no match, then delete of the first of two equal keys.
    queue_cmd(CmdDelete, 32'sd7, 1'b0);
    queue_cmd(CmdDelete, '0, 1'b0);
    // Fill the table, then an insert into a full table.
    queue_cmd(CmdInsert, KeyMax, 1'b0);
    queue_cmd(CmdInsert, KeyMin, 1'b0);
    queue_cmd(CmdInsert, 32'sd1, 1'b0);
    queue_cmd(CmdInsert, -32'sd1, 1'b0);
    queue_cmd(CmdInsert, 32'sd2, 1'b0);
    queue_cmd(CmdInsert, 32'sh5555_5555, 1'b0);
    queue_cmd(CmdInsert, 32'shAAAA_AAAA, 1'b0);
    queue_cmd(CmdInsert, 32'sd100, 1'b0);
    queue_cmd(CmdInsert, -32'sd100, 1'b0);
    queue_cmd(CmdInsert, '0, 1'b0);
    queue_cmd(CmdInsert, 32'sd3, 1'b0);
    queue_cmd(CmdInsert, -32'sd3, 1'b0);
    queue_cmd(CmdInsert, 32'sh0000_FFFF, 1'b0);
    queue_cmd(CmdInsert, 32'sd9, 1'b0);
    queue_cmd(CmdList, '0, 1'b0);
    // Delete at the head of the table.
    queue_cmd(CmdDelete, KeyMin, 1'b0);

    // Random part in alternating fill and drain phases; the sender waits for
    // the table to go quiet at the start of some phases.
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < 34; n++)
        queue_cmd(pick_cmd(ph % 2 == 0), pick_key(), (n == 0) && (ph != 1));
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every command has been transferred, then for the results.
    do @(posedge clk_i); while (cmd_queue.size() != 0 || in_valid_i);
    do @(posedge clk_i); while (due_results.size() != 0);
    repeat (DrainWait) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
hdl/skt_pkg.sv
hdl/skt_ram.sv
hdl/skt_cmp.sv
hdl/sorted_key_table_core.sv
test/tb.sv
